/* src/mh64_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mh64_pkg: shared types and constants for the MurmurHash64A stream block
// Holds the mixing constants, the controller states and the command and
// status records that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mh64_pkg;

	localparam logic [63:0] MIX_MULT  = 64'hc6a4a7935bd1e995;
	localparam logic [31:0] MIX_LO    = MIX_MULT[31:0];
	localparam logic [31:0] MIX_HI    = MIX_MULT[63:32];
	localparam int unsigned MIX_SHIFT = 47;

	// Partial products of a 64-bit by constant multiply, one per cycle.
	localparam logic [1:0] STEP_LL = 2'd0;
	localparam logic [1:0] STEP_HL = 2'd1;
	localparam logic [1:0] STEP_LH = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_LEN_MUL,
		ST_LEN_DONE,
		ST_DISPATCH,
		ST_W1_MUL,
		ST_W1_DONE,
		ST_W2_MUL,
		ST_W2_DONE,
		ST_H_MUL,
		ST_H_DONE,
		ST_FIN_PRE,
		ST_F_MUL,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL,
		OP_SEED,
		OP_XW,
		OP_TAIL,
		OP_MIXW,
		OP_XORH,
		OP_SETH,
		OP_FPRE,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] step;
	} dp_cmd_t;

	typedef struct packed {
		logic first;
		logic last;
		logic full;
		logic some;
		logic out_busy;
	} dp_status_t;

endpackage
`default_nettype wire

/* src/mh64_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mh64_datapath: hash registers and shared multiplier
// Holds the running hash, the captured item, the multiplier operand and the
// product accumulator, and the output register towards the result channel.
// ----------------------------------------------------------------------------
module mh64_datapath
	import mh64_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire dp_cmd_t     cmd,
	output dp_status_t       status,
	input  wire logic [63:0] hash_seed,
	input  wire logic [63:0] data_word,
	input  wire logic [3:0]  valid_bytes,
	input  wire logic [30:0] total_length,
	input  wire logic        first,
	input  wire logic        last,
	output logic             hash_valid,
	input  wire logic        hash_stall,
	output logic [63:0]      hash_value
);

	logic [63:0] h_q;
	logic [63:0] x_q;
	logic [63:0] acc_q;
	logic [63:0] word_q;
	logic [3:0]  nb_q;
	logic        first_q;
	logic        last_q;
	logic [63:0] hash_q;
	logic        hash_valid_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [63:0] tail_mask;

	// One 32 by 32 partial product a cycle; the high cross terms only reach
	// the upper half of the truncated 64-bit result.
	always_comb begin
		mul_a = (cmd.step == STEP_HL) ? x_q[63:32] : x_q[31:0];
		mul_b = (cmd.step == STEP_LH) ? MIX_HI : MIX_LO;
		prod  = 64'(mul_a) * 64'(mul_b);
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			tail_mask[8*i +: 8] = (4'(i) < nb_q) ? 8'hff : 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				word_q  <= data_word;
				nb_q    <= valid_bytes;
				first_q <= first;
				last_q  <= last;
				x_q     <= {33'b0, total_length};
			end
			OP_MUL: begin
				if (cmd.step == STEP_LL) begin
					acc_q <= prod;
				end else begin
					acc_q[63:32] <= acc_q[63:32] + prod[31:0];
				end
			end
			OP_XW:   x_q <= word_q;
			OP_TAIL: x_q <= h_q ^ (word_q & tail_mask);
			OP_MIXW: x_q <= acc_q ^ (acc_q >> MIX_SHIFT);
			OP_XORH: x_q <= h_q ^ acc_q;
			OP_FPRE: x_q <= h_q ^ (h_q >> MIX_SHIFT);
			OP_OUT:  hash_q <= acc_q ^ (acc_q >> MIX_SHIFT);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= '0;
		end else if (cmd.op == OP_SEED) begin
			h_q <= hash_seed ^ acc_q;
		end else if (cmd.op == OP_SETH) begin
			h_q <= acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_valid_q <= 1'b0;
		end else if (cmd.op == OP_OUT) begin
			hash_valid_q <= 1'b1;
		end else if (!hash_stall) begin
			hash_valid_q <= 1'b0;
		end
	end

	always_comb begin
		status.first    = first_q;
		status.last     = last_q;
		status.full     = nb_q[3];
		status.some     = (nb_q != 4'd0);
		status.out_busy = hash_valid_q && hash_stall;
	end

	assign hash_valid = hash_valid_q;
	assign hash_value = hash_q;

endmodule
`default_nettype wire

/* src/mh64_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mh64_ctrl: sequencer for the MurmurHash64A stream block
// Steps each item through the start value, block or tail mixing and the
// final avalanche, driving the shared multiplier one partial product at a time.
// ----------------------------------------------------------------------------
module mh64_ctrl
	import mh64_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_stall,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd
);

	state_t     state_q;
	state_t     state_next;
	logic [1:0] step_q;
	logic       mul_state;
	logic       mul_end;

	assign mul_state = (state_q == ST_LEN_MUL) || (state_q == ST_W1_MUL) ||
		(state_q == ST_W2_MUL) || (state_q == ST_H_MUL) || (state_q == ST_F_MUL);
	assign mul_end = mul_state && (step_q == STEP_LH);

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE:     if (item_valid) state_next = ST_START;
			ST_START:    state_next = status.first ? ST_LEN_MUL : ST_DISPATCH;
			ST_LEN_MUL:  if (mul_end) state_next = ST_LEN_DONE;
			ST_LEN_DONE: state_next = ST_DISPATCH;
			ST_DISPATCH: begin
				if (status.full) begin
					state_next = ST_W1_MUL;
				end else if (status.some) begin
					state_next = ST_H_MUL;
				end else if (status.last) begin
					state_next = ST_F_MUL;
				end else begin
					state_next = ST_IDLE;
				end
			end
			ST_W1_MUL:   if (mul_end) state_next = ST_W1_DONE;
			ST_W1_DONE:  state_next = ST_W2_MUL;
			ST_W2_MUL:   if (mul_end) state_next = ST_W2_DONE;
			ST_W2_DONE:  state_next = ST_H_MUL;
			ST_H_MUL:    if (mul_end) state_next = ST_H_DONE;
			ST_H_DONE:   state_next = status.last ? ST_FIN_PRE : ST_IDLE;
			ST_FIN_PRE:  state_next = ST_F_MUL;
			ST_F_MUL:    if (mul_end) state_next = ST_OUT;
			ST_OUT:      if (!status.out_busy) state_next = ST_IDLE;
			default:     state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op     = OP_NONE;
		cmd.step   = step_q;
		item_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE:     if (item_valid) cmd.op = OP_LOAD;
			ST_LEN_MUL,
			ST_W1_MUL,
			ST_W2_MUL,
			ST_H_MUL,
			ST_F_MUL:    cmd.op = OP_MUL;
			ST_LEN_DONE: cmd.op = OP_SEED;
			ST_DISPATCH: begin
				if (status.full) begin
					cmd.op = OP_XW;
				end else if (status.some) begin
					cmd.op = OP_TAIL;
				end else if (status.last) begin
					cmd.op = OP_FPRE;
				end
			end
			ST_W1_DONE:  cmd.op = OP_MIXW;
			ST_W2_DONE:  cmd.op = OP_XORH;
			ST_H_DONE:   cmd.op = OP_SETH;
			ST_FIN_PRE:  cmd.op = OP_FPRE;
			ST_OUT:      if (!status.out_busy) cmd.op = OP_OUT;
			default:     cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= STEP_LL;
		end else begin
			state_q <= state_next;
			if (mul_end || !mul_state) begin
				step_q <= STEP_LL;
			end else begin
				step_q <= step_q + 2'd1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> (state_q == ST_START))
		else $error("accepted item did not start the sequence");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == STEP_LL) || (step_q == STEP_HL) || (step_q == STEP_LH))
		else $error("multiplier step out of range");

	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!mul_state |-> (step_q == STEP_LL))
		else $error("multiplier step not cleared outside a multiply");
`endif

endmodule
`default_nettype wire

/* src/murmur_hash64a_stream.sv */
// The result is registered in the OUT state after the final multiply, held until
// taken. A new item is taken only once the sequence for the last one is idle.
// Each 64-bit multiply by the constant runs as the low, high-low and low-high
// partial products on one shared 32 by 32 multiplier.
// Reset clears the running hash, the seed and the controller to idle.
`default_nettype none
// ----------------------------------------------------------------------------
// murmur_hash64a_stream: streaming MurmurHash64A
// Hashes a byte string arriving as little-endian 64-bit words and gives the
// 64-bit hash on the last item; the seed is set through an APB-style port.
// ----------------------------------------------------------------------------
module murmur_hash64a_stream
	import mh64_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [63:0] data_word,
	input  wire logic [3:0]  valid_bytes,
	input  wire logic [30:0] total_length,
	input  wire logic        first,
	input  wire logic        last,
	output logic             hash_valid,
	input  wire logic        hash_stall,
	output logic [63:0]      hash_value
);

	logic [63:0] hash_seed_q;
	logic        seed_sel;
	dp_cmd_t     cmd;
	dp_status_t  status;

	// Only the seed register exists; byte addresses 0 to 7 select it.
	assign seed_sel = !paddr[3];
	assign pready   = 1'b1;
	assign prdata   = seed_sel ? hash_seed_q : 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_seed_q <= '0;
		end else if (psel && penable && pwrite && seed_sel) begin
			hash_seed_q <= pwdata;
		end
	end

	mh64_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	mh64_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.hash_seed    (hash_seed_q),
		.data_word    (data_word),
		.valid_bytes  (valid_bytes),
		.total_length (total_length),
		.first        (first),
		.last         (last),
		.hash_valid   (hash_valid),
		.hash_stall   (hash_stall),
		.hash_value   (hash_value)
	);

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_OUT) |-> !(hash_valid && hash_stall))
		else $error("result register overwritten while an item waits");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_LOAD) |-> (item_valid && !item_stall))
		else $error("item captured without an accept");

	a_result_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hash_valid) |-> $past(cmd.op == OP_OUT))
		else $error("result raised without a final multiply");
`endif

endmodule
`default_nettype wire

/* dv/murmur_hash64a_stream_checker.sv */
// ----------------------------------------------------------------------------
// murmur_hash64a_stream_checker: hash predictor and scoreboard
// Watches the seed register port and the item and hash channels, works out the
// 64-bit hash of every string that closes, and compares each hash that
// leaves the block against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module murmur_hash64a_stream_checker #(
	parameter logic [3:0] SEED_ADDR = 4'd0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic        item_valid,
	input  logic        item_stall,
	input  logic [63:0] data_word,
	input  logic [3:0]  valid_bytes,
	input  logic [30:0] total_length,
	input  logic        first,
	input  logic        last,
	input  logic        hash_valid,
	input  logic        hash_stall,
	input  logic [63:0] hash_value,
	output logic [31:0] pending_hashes,
	output logic [31:0] mismatch_count
);

	localparam logic [63:0] MURMUR_M     = 64'hc6a4a7935bd1e995;
	localparam int unsigned MURMUR_SHIFT = 47;

	logic [63:0] seed_reg   = '0;
	logic [63:0] chain_hash = '0;
	logic [63:0] expected_hashes[$];
	int unsigned outstanding = 0;
	int unsigned errors      = 0;

	assign pending_hashes = outstanding;
	assign mismatch_count = errors;

	function automatic logic [63:0] mix_full_word(logic [63:0] h, logic [63:0] w);
		logic [63:0] k;
		k = w * MURMUR_M;
		k = k ^ (k >> MURMUR_SHIFT);
		k = k * MURMUR_M;
		return (h ^ k) * MURMUR_M;
	endfunction

	function automatic logic [63:0] mix_partial_word(logic [63:0] h, logic [63:0] w,
			int unsigned n);
		logic [63:0] keep;
		keep = (64'd1 << (8 * n)) - 64'd1;
		return (h ^ (w & keep)) * MURMUR_M;
	endfunction

	function automatic logic [63:0] avalanche_hash(logic [63:0] h);
		logic [63:0] x;
		x = h ^ (h >> MURMUR_SHIFT);
		x = x * MURMUR_M;
		return x ^ (x >> MURMUR_SHIFT);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [63:0] h;
		logic [63:0] want;
		if (!arst_n) begin
			seed_reg   = '0;
			chain_hash = '0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == SEED_ADDR)
				seed_reg = pwdata;

			// Hashes leave before the item taken at the same edge can close a string.
			if (hash_valid && !hash_stall) begin
				if (expected_hashes.size() == 0) begin
					$display("%0t: hash %h arrived with none expected", $time, hash_value);
					errors++;
				end else begin
					want = expected_hashes.pop_front();
					if (hash_value !== want) begin
						$display("%0t: hash_value expected %h actual %h", $time, want,
							hash_value);
						errors++;
					end
				end
			end

			if (item_valid && !item_stall) begin
				h = first ? (seed_reg ^ ({33'd0, total_length} * MURMUR_M)) : chain_hash;
				if (valid_bytes >= 4'd8)
					h = mix_full_word(h, data_word);
				else if (valid_bytes != 4'd0)
					h = mix_partial_word(h, data_word, 32'(valid_bytes));
				chain_hash = h;
				if (last)
					expected_hashes.push_back(avalanche_hash(h));
			end
			outstanding = expected_hashes.size();
		end
	end

endmodule

/* dv/murmur_hash64a_stream_tb.sv */
// ----------------------------------------------------------------------------
// murmur_hash64a_stream_tb: regression for the MurmurHash64A stream block
// Sends directed strings covering every byte count from 0 to 8, some counts over 8
// and the odd item orders, then random strings with some stray items, under several seeds and with
// varying idle and stall patterns on both channels. A checker beside the
// block predicts and compares every hash.
// ----------------------------------------------------------------------------
module murmur_hash64a_stream_tb;

	localparam logic [3:0]  SEED_ADDR     = 4'd0;
	localparam int unsigned SETTLE_CYCLES = 48;
	localparam int unsigned LONG_HOLD     = 300;
	localparam int unsigned CYCLE_LIMIT   = 500000;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        psel         = 1'b0;
	logic        penable      = 1'b0;
	logic        pwrite       = 1'b0;
	logic [3:0]  paddr        = '0;
	logic [63:0] pwdata       = '0;
	logic [63:0] prdata;
	logic        pready;
	logic        item_valid   = 1'b0;
	logic        item_stall;
	logic [63:0] data_word    = '0;
	logic [3:0]  valid_bytes  = '0;
	logic [30:0] total_length = '0;
	logic        first        = 1'b0;
	logic        last         = 1'b0;
	logic        hash_valid;
	logic        hash_stall   = 1'b0;
	logic [63:0] hash_value;
	logic [31:0] pending_hashes;
	logic [31:0] mismatch_count;

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned items_sent     = 0;
	int unsigned hold_requests  = 0;
	int unsigned holds_started  = 0;
	int unsigned hold_left      = 0;
	int unsigned cycle_count    = 0;

	murmur_hash64a_stream u_top (.*);

	murmur_hash64a_stream_checker #(.SEED_ADDR(SEED_ADDR)) u_checker (.*);

	always #5 clk = ~clk;

	// The receiver either stalls at random or sits out a long hold on request.
	always @(posedge clk) begin
		if (hold_requests != holds_started) begin
			holds_started <= holds_started + 1;
			hold_left     <= LONG_HOLD;
			hash_stall    <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left  <= hold_left - 1;
			hash_stall <= 1'b1;
		end else begin
			hash_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic write_seed(input logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= SEED_ADDR;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic send_item(input logic [63:0] word, input logic [3:0] nbytes,
			input logic [30:0] length, input logic is_first, input logic is_last);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid   <= 1'b1;
		data_word    <= word;
		valid_bytes  <= nbytes;
		total_length <= length;
		first        <= is_first;
		last         <= is_last;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// Splits a string into words; bytes past the valid count carry junk.
	task automatic send_string(input int unsigned length);
		int unsigned left;
		int unsigned take;
		logic [3:0]  nbytes;
		logic        opening;
		if (length == 0) begin
			send_item({$urandom, $urandom}, 4'd0, 31'd0, 1'b1, 1'b1);
		end else begin
			left    = length;
			opening = 1'b1;
			while (left != 0) begin
				take   = (left >= 8) ? 8 : left;
				nbytes = 4'(take);
				if (take == 8 && $urandom_range(7) == 0)
					nbytes = 4'(8 + $urandom_range(7));
				send_item({$urandom, $urandom}, nbytes, 31'(length), opening,
					left == take);
				opening = 1'b0;
				left    = left - take;
			end
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending_hashes != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(input int unsigned item_target);
		int unsigned pick;
		while (items_sent < item_target) begin
			pick = $urandom_range(99);
			if (pick < 10)
				send_item({$urandom, $urandom}, 4'($urandom_range(15)), 31'($urandom),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			else if (pick < 75)
				send_string($urandom_range(24));
			else if (pick < 97)
				send_string($urandom_range(80, 25));
			else
				send_string($urandom_range(400, 81));
		end
		item_valid <= 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings under the reset seed.
		send_item(64'h0123456789abcdef, 4'd8, 31'd0, 1'b0, 1'b1);
		send_item(64'hffffffffffffffff, 4'd0, 31'd0, 1'b1, 1'b1);
		send_item(64'hffffffffffffffff, 4'd8, 31'd8, 1'b1, 1'b1);
		send_item(64'h0, 4'd8, 31'h7fffffff, 1'b1, 1'b1);
		for (int n = 1; n < 8; n++)
			send_item({$urandom, $urandom}, 4'(n), 31'(n), 1'b1, 1'b1);
		send_item({$urandom, $urandom}, 4'd9, 31'd8, 1'b1, 1'b1);
		send_item({$urandom, $urandom}, 4'd12, 31'd8, 1'b1, 1'b1);
		send_item({$urandom, $urandom}, 4'd15, 31'd8, 1'b1, 1'b1);
		// A short word opening a string, then an empty word, then more data.
		send_item({$urandom, $urandom}, 4'd3, 31'd16, 1'b1, 1'b0);
		send_item({$urandom, $urandom}, 4'd0, 31'd0, 1'b0, 1'b0);
		send_item({$urandom, $urandom}, 4'd8, 31'd0, 1'b0, 1'b0);
		send_item({$urandom, $urandom}, 4'd5, 31'd0, 1'b0, 1'b1);
		// A new string opens before the previous one was closed.
		send_item({$urandom, $urandom}, 4'd8, 31'd24, 1'b1, 1'b0);
		send_item({$urandom, $urandom}, 4'd8, 31'd8, 1'b1, 1'b1);
		// An item carrying on from the hash left by a closed string.
		send_item({$urandom, $urandom}, 4'd6, 31'd0, 1'b0, 1'b1);
		item_valid <= 1'b0;
		wait_idle();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 7;
					recv_stall_pct = 55;
					write_seed(64'hffffffffffffffff);
				end
				1: begin
					send_idle_pct  = 55;
					recv_stall_pct = 7;
					write_seed({$urandom, $urandom});
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
					write_seed(64'h0);
				end
			endcase
			// The receiver holds off while items keep coming, so the block backs up.
			hold_requests <= hold_requests + 1;
			run_random(20 + (phase + 1) * 377);
			wait_idle();
		end

		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
